>>> design/rfp_symmetric_matrix_norm_core_macros.svh
// Assertion macros for the RFP symmetric matrix norm core.
// Used by the top level; expects clk and rst in scope.
`ifndef RFP_SYMMETRIC_MATRIX_NORM_CORE_MACROS_SVH
`define RFP_SYMMETRIC_MATRIX_NORM_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RFPN_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RFPN_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/rfpn_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// RFP symmetric matrix norm core. No dependencies.
package rfpn_pkg;

  localparam int MAX_ORDER = 64;
  localparam int ORD_W     = $clog2(MAX_ORDER + 2);
  localparam int CMP_W     = (ORD_W > 7) ? ORD_W : 7;
  localparam int MAP_W     = ORD_W + 1;
  localparam int COL_AW    = $clog2(MAX_ORDER);
  localparam int ELEM_W    = 24;
  localparam int NORM_W    = 30;
  localparam int SUM_W     = 30;
  localparam int SQ_W      = 64;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int CFG_W     = 7;
  localparam int IDX_W     = 2;
  localparam int KIND_W    = 2;

  typedef enum logic [IDX_W-1:0] {
    REG_KIND   = 2'd0,
    REG_LAYOUT = 2'd1,
    REG_UPPER  = 2'd2,
    REG_ORDER  = 2'd3
  } cfg_reg_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_MAX  = 2'd0,
    KIND_ONE  = 2'd1,
    KIND_FROB = 2'd2,
    KIND_ZERO = 2'd3
  } norm_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_R,
    S_WR_R,
    S_RD_C,
    S_WR_C,
    S_FIN,
    S_ROOT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_r;
    logic wr_r;
    logic rd_c;
    logic wr_c;
    logic root_start;
    logic root_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic diag;
    logic last;
    logic frob;
    logic root_done;
    logic out_busy;
  } status_t;

endpackage

>>> design/rfpn_isqrt.sv
// Iterative integer square root, one result bit per cycle while step is high.
// Depends on rfpn_pkg.
module rfpn_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        step,
  input  logic [rfpn_pkg::SQ_W-1:0]   radicand,
  output logic                        done,
  output logic [rfpn_pkg::ROOT_W-1:0] root
);

  logic [rfpn_pkg::SQ_W-1:0] rem;
  logic [rfpn_pkg::SQ_W-1:0] acc;
  logic [rfpn_pkg::SQ_W-1:0] probe;
  logic [rfpn_pkg::SQ_W-1:0] trial;

  assign trial = acc + probe;
  assign done  = (probe == '0);
  assign root  = acc[rfpn_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      probe <= '0;
    end else if (start) begin
      probe <= rfpn_pkg::SQ_W'(1) << (rfpn_pkg::SQ_W - 2);
    end else if (step && !done) begin
      probe <= probe >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= radicand;
      acc <= '0;
    end else if (step && !done) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        acc <= (acc >> 1) + probe;
      end else begin
        acc <= acc >> 1;
      end
    end
  end

endmodule

>>> design/rfpn_ctrl.sv
// Sequencer for the RFP norm core: request intake, column read-modify-write,
// root iteration and result hand-off. Depends on rfpn_pkg.
module rfpn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rfpn_pkg::status_t status,
  output rfpn_pkg::cmd_t    cmd
);

  rfpn_pkg::state_t state;
  rfpn_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfpn_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rfpn_pkg::S_IDLE: if (in_valid) state_next = rfpn_pkg::S_RD_R;
      rfpn_pkg::S_RD_R: state_next = rfpn_pkg::S_WR_R;
      rfpn_pkg::S_WR_R: begin
        if (!status.diag) state_next = rfpn_pkg::S_RD_C;
        else if (status.last) state_next = rfpn_pkg::S_FIN;
        else state_next = rfpn_pkg::S_IDLE;
      end
      rfpn_pkg::S_RD_C: state_next = rfpn_pkg::S_WR_C;
      rfpn_pkg::S_WR_C: state_next = status.last ? rfpn_pkg::S_FIN : rfpn_pkg::S_IDLE;
      rfpn_pkg::S_FIN:  state_next = status.frob ? rfpn_pkg::S_ROOT : rfpn_pkg::S_EMIT;
      rfpn_pkg::S_ROOT: if (status.root_done) state_next = rfpn_pkg::S_EMIT;
      rfpn_pkg::S_EMIT: if (!status.out_busy) state_next = rfpn_pkg::S_IDLE;
      default:          state_next = rfpn_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = (state != rfpn_pkg::S_IDLE);
    unique case (state)
      rfpn_pkg::S_IDLE: cmd.load = in_valid;
      rfpn_pkg::S_RD_R: cmd.rd_r = 1'b1;
      rfpn_pkg::S_WR_R: cmd.wr_r = 1'b1;
      rfpn_pkg::S_RD_C: cmd.rd_c = 1'b1;
      rfpn_pkg::S_WR_C: cmd.wr_c = 1'b1;
      rfpn_pkg::S_FIN:  cmd.root_start = status.frob;
      rfpn_pkg::S_ROOT: cmd.root_step = 1'b1;
      rfpn_pkg::S_EMIT: cmd.emit = !status.out_busy;
      default:          cmd = '0;
    endcase
  end

endmodule

>>> design/rfpn_dpath.sv
// Datapath of the RFP norm core: configuration registers, RFP position
// mapping, column-sum memory, accumulators and output register.
// Depends on rfpn_pkg and rfpn_isqrt.
module rfpn_dpath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [rfpn_pkg::IDX_W-1:0]  cfg_index,
  input  logic [rfpn_pkg::CFG_W-1:0]  cfg_data,
  input  logic signed [rfpn_pkg::ELEM_W-1:0] element,
  input  rfpn_pkg::cmd_t              cmd,
  output rfpn_pkg::status_t           status,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [rfpn_pkg::NORM_W-1:0] norm_value
);

  localparam int ORD_W  = rfpn_pkg::ORD_W;
  localparam int MAP_W  = rfpn_pkg::MAP_W;
  localparam int COL_AW = rfpn_pkg::COL_AW;
  localparam int SUM_W  = rfpn_pkg::SUM_W;
  localparam int SQ_W   = rfpn_pkg::SQ_W;
  localparam int ELEM_W = rfpn_pkg::ELEM_W;
  localparam int NORM_W = rfpn_pkg::NORM_W;

  // configuration
  logic [rfpn_pkg::KIND_W-1:0] norm_kind;
  logic                        layout_transposed;
  logic                        from_upper;
  logic [rfpn_pkg::CFG_W-1:0]  order;
  logic                        cfg_clear;
  logic                        clear_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_kind         <= '0;
      layout_transposed <= 1'b0;
      from_upper        <= 1'b0;
      order             <= rfpn_pkg::CFG_W'(1);
    end else if (cfg_write) begin
      unique case (rfpn_pkg::cfg_reg_t'(cfg_index))
        rfpn_pkg::REG_KIND:   norm_kind <= cfg_data[rfpn_pkg::KIND_W-1:0];
        rfpn_pkg::REG_LAYOUT: layout_transposed <= cfg_data[0];
        rfpn_pkg::REG_UPPER:  from_upper <= cfg_data[0];
        rfpn_pkg::REG_ORDER:  order <= cfg_data;
        default:              norm_kind <= norm_kind;
      endcase
    end
  end

  assign cfg_clear = cfg_write && (rfpn_pkg::cfg_reg_t'(cfg_index) != rfpn_pkg::REG_KIND);
  assign clear_all = cfg_clear || cmd.emit;

  // array shape
  logic [rfpn_pkg::CMP_W-1:0] n_ext;
  logic [ORD_W-1:0] n_eff, half, ceil_half, long_dim, rows, cols;
  logic [ORD_W-1:0] srow, scol, pos_i, pos_j;
  logic             last_pos;

  always_comb begin
    n_ext = rfpn_pkg::CMP_W'(order);
    if (order == '0) n_eff = ORD_W'(1);
    else if (n_ext > rfpn_pkg::CMP_W'(rfpn_pkg::MAX_ORDER)) n_eff = ORD_W'(rfpn_pkg::MAX_ORDER);
    else n_eff = n_ext[ORD_W-1:0];
    half      = n_eff >> 1;
    ceil_half = half + ORD_W'(n_eff[0]);
    long_dim  = n_eff + ORD_W'(!n_eff[0]);
    rows      = layout_transposed ? ceil_half : long_dim;
    cols      = layout_transposed ? long_dim : ceil_half;
    pos_i     = layout_transposed ? scol : srow;
    pos_j     = layout_transposed ? srow : scol;
    last_pos  = (srow == rows - ORD_W'(1)) && (scol == cols - ORD_W'(1));
  end

  // map packed position to matrix entry (row, col)
  logic [MAP_W-1:0] ie, je, he, pe, rr, cc;

  always_comb begin
    ie = MAP_W'(pos_i);
    je = MAP_W'(pos_j);
    he = MAP_W'(half);
    pe = MAP_W'(ceil_half);
    if (from_upper) begin
      if (ie <= he + je) begin
        rr = ie;
        cc = he + je;
      end else begin
        rr = je;
        cc = ie - he - MAP_W'(1);
      end
    end else if (!n_eff[0]) begin
      if (ie <= je) begin
        rr = he + je;
        cc = he + ie;
      end else begin
        rr = ie - MAP_W'(1);
        cc = je;
      end
    end else begin
      if (ie < je) begin
        rr = pe + je - MAP_W'(1);
        cc = pe + ie;
      end else begin
        rr = ie;
        cc = je;
      end
    end
  end

  // position counters
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      srow <= '0;
      scol <= '0;
    end else if (cmd.load) begin
      if (srow == rows - ORD_W'(1)) begin
        srow <= '0;
        scol <= scol + ORD_W'(1);
      end else begin
        srow <= srow + ORD_W'(1);
      end
    end
  end

  // captured request
  logic [ELEM_W-1:0]   mag, mag_q;
  logic [COL_AW-1:0]   r_q, c_q;
  logic                diag_q, last_q;
  logic [2*ELEM_W-1:0] sq_q;

  assign mag = element[ELEM_W-1] ? ELEM_W'(-element) : ELEM_W'(element);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_q  <= mag;
      r_q    <= rr[COL_AW-1:0];
      c_q    <= cc[COL_AW-1:0];
      diag_q <= (rr == cc);
      last_q <= last_pos;
    end
    if (cmd.rd_r) sq_q <= mag_q * mag_q;
  end

  // column sums: single-port memory with flop valid bits
  logic [SUM_W-1:0]     col_mem [rfpn_pkg::MAX_ORDER];
  logic [rfpn_pkg::MAX_ORDER-1:0] col_vld;
  logic [COL_AW-1:0]    mem_addr;
  logic                 mem_we;
  logic [SUM_W-1:0]     rd_data, old_sum, wr_data;
  logic                 rd_vld;
  logic [SUM_W:0]       col_tot;

  assign mem_addr = (cmd.rd_c || cmd.wr_c) ? c_q : r_q;
  assign mem_we   = cmd.wr_r || cmd.wr_c;
  assign old_sum  = rd_vld ? rd_data : '0;
  assign col_tot  = {1'b0, old_sum} + (SUM_W + 1)'(mag_q);
  assign wr_data  = col_tot[SUM_W] ? {SUM_W{1'b1}} : col_tot[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) col_mem[mem_addr] <= wr_data;
    rd_data <= col_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      col_vld <= '0;
    end else if (mem_we) begin
      col_vld[mem_addr] <= 1'b1;
    end
    rd_vld <= col_vld[mem_addr];
  end

  // accumulators
  logic [ELEM_W-1:0]   running_max;
  logic [SUM_W-1:0]    best_col;
  logic [SQ_W-1:0]     square_sum;
  logic [2*ELEM_W:0]   sq_add;
  logic [SQ_W:0]       sq_tot;

  assign sq_add = diag_q ? {1'b0, sq_q} : {sq_q, 1'b0};
  assign sq_tot = {1'b0, square_sum} + (SQ_W + 1)'(sq_add);

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      running_max <= '0;
      best_col    <= '0;
      square_sum  <= '0;
    end else begin
      if (cmd.rd_r && (mag_q > running_max)) running_max <= mag_q;
      if (mem_we && (wr_data > best_col)) best_col <= wr_data;
      if (cmd.wr_r) square_sum <= sq_tot[SQ_W] ? {SQ_W{1'b1}} : sq_tot[SQ_W-1:0];
    end
  end

  // Frobenius root
  logic                        root_done;
  logic [rfpn_pkg::ROOT_W-1:0] root;

  rfpn_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.root_start),
    .step     (cmd.root_step),
    .radicand (square_sum),
    .done     (root_done),
    .root     (root)
  );

  // result select and output register
  logic [NORM_W-1:0] result;

  always_comb begin
    unique case (rfpn_pkg::norm_kind_t'(norm_kind))
      rfpn_pkg::KIND_MAX:  result = NORM_W'(running_max);
      rfpn_pkg::KIND_ONE:  result = best_col;
      rfpn_pkg::KIND_FROB: result = (root > rfpn_pkg::ROOT_W'({NORM_W{1'b1}}))
                                    ? {NORM_W{1'b1}} : root[NORM_W-1:0];
      rfpn_pkg::KIND_ZERO: result = '0;
      default:             result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) norm_value <= result;
  end

  always_comb begin
    status.diag      = diag_q;
    status.last      = last_q;
    status.frob      = (rfpn_pkg::norm_kind_t'(norm_kind) == rfpn_pkg::KIND_FROB);
    status.root_done = root_done;
    status.out_busy  = out_valid && out_stall;
  end

endmodule

>>> design/rfp_symmetric_matrix_norm_core.sv
// Top level of the RFP symmetric matrix norm core.
// Depends on rfpn_pkg, rfpn_ctrl, rfpn_dpath and the assertion macro header.
//
// Accepts the n(n+1)/2 packed elements of a symmetric matrix in RFP storage
// order (signed Q8.16, one request per handshake) and returns one norm per
// matrix after its last element: max |a|, one/infinity norm, Frobenius norm
// (Q.16, saturated at 2^30-1), or zero, chosen by norm_kind at matrix end.
// Each element first has its position mapped; the column sums sit in a
// single-port memory, so every touched column then costs a read and a write,
// one column on the diagonal and two off it. After the last element the
// result is handed to the output register; for the Frobenius norm the square
// root runs first and produces one bit per cycle. The hand-off waits while the
// previous result is still stalled in the output register; once it is taken,
// the next request is accepted even while the new result sits stalled.
// Column sums are tracked with per-entry valid bits, so no clearing pass runs
// after reset or between matrices. Write configuration only while idle; a
// write to layout, triangle or order drops the matrix in progress.
`include "rfp_symmetric_matrix_norm_core_macros.svh"

module rfp_symmetric_matrix_norm_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [rfpn_pkg::IDX_W-1:0]         cfg_index,
  input  logic [rfpn_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [rfpn_pkg::ELEM_W-1:0] element,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rfpn_pkg::NORM_W-1:0]        norm_value
);

  rfpn_pkg::cmd_t    cmd;
  rfpn_pkg::status_t status;

  // sequencer: advance through map, column updates, root and hand-off
  rfpn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: hold configuration, accumulate, drive the result register
  rfpn_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .element    (element),
    .cmd        (cmd),
    .status     (status),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .norm_value (norm_value)
  );

  // an accepted request keeps the block busy for its column updates
  `RFPN_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "request accepted back to back")
  // never overwrite a result that is still stalled
  `RFPN_ASSERT_IMP(a_emit_into_free, cmd.emit, !(out_valid && out_stall), "result overwritten while stalled")
  // a result appears only after the sequencer hands one off
  `RFPN_ASSERT_IMP(a_out_from_emit, $rose(out_valid), $past(cmd.emit), "result valid without hand-off")

endmodule

>>> tb/testbench.sv
// Testbench for the RFP symmetric matrix norm core: drives packed matrices
// through the valid/stall ports and checks every norm against a local predictor.
// Depends on rfpn_pkg and the rfp_symmetric_matrix_norm_core top level.
module testbench;

  localparam int STEP_SLACK = 60;

  logic                               clk;
  logic                               rst;
  logic                               cfg_write;
  logic [rfpn_pkg::IDX_W-1:0]         cfg_index;
  logic [rfpn_pkg::CFG_W-1:0]         cfg_data;
  logic                               in_valid;
  logic                               in_stall;
  logic signed [rfpn_pkg::ELEM_W-1:0] element;
  logic                               out_valid;
  logic                               out_stall;
  logic [rfpn_pkg::NORM_W-1:0]        norm_value;

  rfp_symmetric_matrix_norm_core u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .element(element),
    .out_valid(out_valid), .out_stall(out_stall), .norm_value(norm_value)
  );

  // Predictor copy of configuration and per-matrix state.
  rfpn_pkg::norm_kind_t pk_kind;
  logic        pk_trans;
  logic        pk_upper;
  logic [6:0]  pk_order;
  logic [29:0] pk_cols [rfpn_pkg::MAX_ORDER];
  logic [23:0] pk_max;
  logic [63:0] pk_sq;
  int unsigned pk_row, pk_col, pk_seen;

  logic [rfpn_pkg::NORM_W-1:0] norm_queue [$];
  int mismatches;
  int sender_idle_pct, receiver_idle_pct;
  bit hold_receiver;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #60000000;
    $display("Mismatches found");
    $finish;
  end

  task automatic report(input string what, input logic [rfpn_pkg::NORM_W-1:0] got,
                        input logic [rfpn_pkg::NORM_W-1:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  function automatic void clear_matrix();
    for (int k = 0; k < rfpn_pkg::MAX_ORDER; k++) pk_cols[k] = '0;
    pk_max = '0;
    pk_sq = '0;
    pk_row = 0;
    pk_col = 0;
    pk_seen = 0;
  endfunction

  function automatic void apply_register(rfpn_pkg::cfg_reg_t idx,
                                         logic [rfpn_pkg::CFG_W-1:0] val);
    case (idx)
      rfpn_pkg::REG_KIND: pk_kind = rfpn_pkg::norm_kind_t'(val[1:0]);
      rfpn_pkg::REG_LAYOUT: begin pk_trans = val[0]; clear_matrix(); end
      rfpn_pkg::REG_UPPER: begin pk_upper = val[0]; clear_matrix(); end
      rfpn_pkg::REG_ORDER: begin pk_order = val[6:0]; clear_matrix(); end
      default: ;
    endcase
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic void add_to_column(int unsigned idx, logic [29:0] mag);
    logic [30:0] t;
    if (idx >= rfpn_pkg::MAX_ORDER) return;
    t = pk_cols[idx] + mag;
    pk_cols[idx] = t[30] ? 30'h3FFFFFFF : t[29:0];
  endfunction

  function automatic int unsigned matrix_order();
    if (pk_order == 0) return 1;
    if (pk_order > rfpn_pkg::MAX_ORDER) return rfpn_pkg::MAX_ORDER;
    return pk_order;
  endfunction

  // Accumulate one element; return 1 and the norm when the matrix closes.
  function automatic bit accumulate_element(logic [23:0] raw,
                                            output logic [rfpn_pkg::NORM_W-1:0] nv);
    int unsigned n, h, p, rows, cols, i, j, r, c, best;
    logic [23:0] mag;
    longint unsigned sq, root;
    n = matrix_order();
    h = n / 2;
    p = (n + 1) / 2;
    rows = pk_trans ? p : n + ((n % 2) == 0);
    cols = pk_trans ? n + ((n % 2) == 0) : p;
    mag = raw[23] ? (24'h0 - raw) : raw;
    nv = '0;
    if (pk_row >= rows || pk_col >= cols) clear_matrix();
    i = pk_trans ? pk_col : pk_row;
    j = pk_trans ? pk_row : pk_col;
    if (pk_upper) begin
      if (i <= h + j) begin r = i; c = h + j; end
      else begin r = j; c = i - h - 1; end
    end else if ((n % 2) == 0) begin
      if (i <= j) begin r = h + j; c = h + i; end
      else begin r = i - 1; c = j; end
    end else begin
      if (i < j) begin r = p + j - 1; c = p + i; end
      else begin r = i; c = j; end
    end
    if (mag > pk_max) pk_max = mag;
    sq = longint'(mag) * longint'(mag);
    if (r != c) begin
      sq <<= 1;
      add_to_column(r, 30'(mag));
      add_to_column(c, 30'(mag));
    end else begin
      add_to_column(r, 30'(mag));
    end
    pk_sq = (pk_sq > 64'hFFFFFFFFFFFFFFFF - sq) ? 64'hFFFFFFFFFFFFFFFF : pk_sq + sq;
    pk_seen++;
    pk_row++;
    if (pk_row >= rows) begin
      pk_row = 0;
      pk_col++;
    end
    if (pk_seen < rows * cols) return 0;
    case (pk_kind)
      rfpn_pkg::KIND_MAX: nv = rfpn_pkg::NORM_W'(pk_max);
      rfpn_pkg::KIND_ONE: begin
        best = 0;
        for (int k = 0; k < n && k < rfpn_pkg::MAX_ORDER; k++)
          if (pk_cols[k] > best) best = pk_cols[k];
        nv = rfpn_pkg::NORM_W'(best);
      end
      rfpn_pkg::KIND_FROB: begin
        root = floor_root(pk_sq);
        nv = (root > 64'h3FFFFFFF) ? 30'h3FFFFFFF : root[29:0];
      end
      default: nv = '0;
    endcase
    clear_matrix();
    return 1;
  endfunction

  // Receiver: random stalls plus an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= hold_receiver || ($urandom_range(99) < receiver_idle_pct);
    end
  end

  // Check each accepted norm against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (norm_queue.size() == 0) begin
        report("unexpected norm", norm_value, '0);
      end else begin
        logic [rfpn_pkg::NORM_W-1:0] want;
        want = norm_queue.pop_front();
        if (norm_value !== want) report("norm_value", norm_value, want);
      end
    end
  end

  // Offer one element request; predict once it is taken. Valid stays up after
  // the accepting edge, also into the next request, until an idle gap or a drain drops it.
  task automatic send_element(input logic [23:0] raw);
    logic [rfpn_pkg::NORM_W-1:0] nv;
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    element <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (accumulate_element(raw, nv)) norm_queue.push_back(nv);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (norm_queue.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (STEP_SLACK) @(posedge clk);
  endtask

  // Write a register only while the block is idle.
  task automatic write_register(input rfpn_pkg::cfg_reg_t idx,
                                input logic [rfpn_pkg::CFG_W-1:0] val);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    apply_register(idx, val);
  endtask

  task automatic set_shape(input rfpn_pkg::norm_kind_t kind, input logic trans,
                           input logic upper, input logic [6:0] ord);
    write_register(rfpn_pkg::REG_KIND, rfpn_pkg::CFG_W'(kind));
    write_register(rfpn_pkg::REG_LAYOUT, rfpn_pkg::CFG_W'(trans));
    write_register(rfpn_pkg::REG_UPPER, rfpn_pkg::CFG_W'(upper));
    write_register(rfpn_pkg::REG_ORDER, rfpn_pkg::CFG_W'(ord));
  endtask

  function automatic logic [23:0] random_element();
    case ($urandom_range(5))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($urandom_range(255));
      3: return 24'hFFFFFF - 24'($urandom_range(255));
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic int unsigned matrix_elements();
    int unsigned n;
    n = matrix_order();
    return n * (n + 1) / 2;
  endfunction

  // Directed rows: value, and for single-element matrices the norm read off directly.
  typedef struct {
    logic [23:0]                 value;
    rfpn_pkg::norm_kind_t        kind;
    bit                          known;
    logic [rfpn_pkg::NORM_W-1:0] norm;
  } directed_row_t;

  directed_row_t directed_rows [] = '{
    '{24'h800000, rfpn_pkg::KIND_MAX, 1, 30'd8388608},
    '{24'h7FFFFF, rfpn_pkg::KIND_MAX, 1, 30'd8388607},
    '{24'h000000, rfpn_pkg::KIND_MAX, 1, 30'd0},
    '{24'hFFFFFF, rfpn_pkg::KIND_ONE, 1, 30'd1},
    '{24'h800000, rfpn_pkg::KIND_ONE, 1, 30'd8388608},
    '{24'h010000, rfpn_pkg::KIND_FROB, 1, 30'd65536},
    '{24'h800000, rfpn_pkg::KIND_FROB, 1, 30'd8388608},
    '{24'h7FFFFF, rfpn_pkg::KIND_ZERO, 1, 30'd0},
    '{24'h123456, rfpn_pkg::KIND_FROB, 0, 30'd0}
  };

  initial begin
    logic [rfpn_pkg::NORM_W-1:0] nv;
    int unsigned m;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = rfpn_pkg::REG_KIND;
    cfg_data = '0;
    in_valid = 1'b0;
    element = '0;
    mismatches = 0;
    hold_receiver = 0;
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    pk_kind = rfpn_pkg::KIND_MAX;
    pk_trans = 0;
    pk_upper = 0;
    pk_order = 7'd1;
    clear_matrix();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: order 1 after reset, so every element closes a matrix.
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind != pk_kind)
        write_register(rfpn_pkg::REG_KIND, rfpn_pkg::CFG_W'(directed_rows[k].kind));
      send_element(directed_rows[k].value);
      if (directed_rows[k].known) begin
        nv = norm_queue[$];
        if (nv !== directed_rows[k].norm) report("directed predictor", nv, directed_rows[k].norm);
      end
    end
    // Order 0 acts as 1, and a shape write mid-matrix drops the partial one.
    set_shape(rfpn_pkg::KIND_ONE, 0, 1, 7'd0);
    send_element(24'h020000);
    write_register(rfpn_pkg::REG_ORDER, 7'd3);
    send_element(24'h7FFFFF);
    send_element(24'h800000);
    write_register(rfpn_pkg::REG_UPPER, 1'b0);
    repeat (6) send_element(24'h800000);
    // An oversized order runs as the maximum until the next shape write drops it.
    write_register(rfpn_pkg::REG_ORDER, 7'd127);
    write_register(rfpn_pkg::REG_KIND, rfpn_pkg::CFG_W'(rfpn_pkg::KIND_FROB));
    for (int k = 0; k < 20; k++) send_element(24'h800000);

    // Random matrices over three idling phases.
    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 66 : 0;
      receiver_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 33 : 0;
      m = 0;
      while (m < 360) begin
        set_shape(rfpn_pkg::norm_kind_t'($urandom_range(3)), 1'($urandom_range(1)),
                  1'($urandom_range(1)),
                  ($urandom_range(19) == 0) ? 7'd0 : 7'($urandom_range(1, 9)));
        if (phase == 2 && m == 0) begin
          write_register(rfpn_pkg::REG_ORDER, 7'd1);
          hold_receiver = 1;
          for (int k = 0; k < 6; k++) send_element(random_element());
          hold_receiver = 0;
        end
        for (int e = matrix_elements(), k = 0; k < e; k++) begin
          send_element(random_element());
          m++;
        end
        if ($urandom_range(3) == 0) drain();
      end
    end

    drain();
    if (mismatches == 0 && norm_queue.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Release a receiver hold after a long stretch, counted here.
  int hold_count;
  always @(posedge clk) begin
    if (rst || !hold_receiver) hold_count <= 0;
    else begin
      hold_count <= hold_count + 1;
      if (hold_count > 300) hold_receiver <= 0;
    end
  end

endmodule
